// ----- src/aabb_pair_contact_tracker_macros.svh -----
// Assertion macros for the AABB pair contact tracker checker.
// Expects signals named clk and rst in the scope of use.
`ifndef AABB_PAIR_CONTACT_TRACKER_MACROS_SVH
`define AABB_PAIR_CONTACT_TRACKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apct assertion failed");

// Next-cycle implication, disabled during reset.
`define APCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apct assertion failed");

`endif

// ----- src/apct_pkg.sv -----
// Shared constants and types for the AABB pair contact tracker.
// No dependencies.
package apct_pkg;

  localparam int ID_BITS_DEFAULT = 6;
  localparam int POS_W           = 16;
  localparam int SIZE_W          = 16;
  localparam int QUEUE_DEPTH     = 2;

  // Contact event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_BEGIN = 2'd1;
  localparam logic [1:0] EV_STAY  = 2'd2;
  localparam logic [1:0] EV_END   = 2'd3;

  // Per-item status carried from the front end to the back end
  typedef struct packed {
    logic ov;
    logic dead;
  } pair_flags_t;

  localparam int FLAGS_W = $bits(pair_flags_t);

endpackage

// ----- src/apct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/apct_front.sv -----
// Front end: accepts pair items, registers axis differences and size sums,
// then classifies overlap on push into the queue. Uses apct_pkg.
module apct_front #(
  parameter int ID_BITS = apct_pkg::ID_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        hold,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ID_BITS-1:0]          left_id,
  input  logic [ID_BITS-1:0]          right_id,
  input  logic signed [apct_pkg::POS_W-1:0] left_x,
  input  logic signed [apct_pkg::POS_W-1:0] left_y,
  input  logic signed [apct_pkg::POS_W-1:0] right_x,
  input  logic signed [apct_pkg::POS_W-1:0] right_y,
  input  logic [apct_pkg::SIZE_W-1:0] left_w,
  input  logic [apct_pkg::SIZE_W-1:0] left_h,
  input  logic [apct_pkg::SIZE_W-1:0] right_w,
  input  logic [apct_pkg::SIZE_W-1:0] right_h,
  input  logic                        left_dead,
  input  logic                        right_dead,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [2*ID_BITS-1:0]        q_idx,
  output apct_pkg::pair_flags_t       q_flags
);

  localparam int DW = apct_pkg::POS_W + 1;   // centre difference
  localparam int SW = apct_pkg::SIZE_W + 1;  // size sum
  localparam int CW = DW + 2;                // compare width

  logic                     fr_valid;
  logic [2*ID_BITS-1:0]     fr_idx;
  logic                     fr_dead;
  logic signed [DW-1:0]     fr_dx;
  logic signed [DW-1:0]     fr_dy;
  logic [SW-1:0]            fr_sx;
  logic [SW-1:0]            fr_sy;
  logic                     accept;
  logic                     ov_x;
  logic                     ov_y;

  // 2|d| <= s  <=>  2d <= s and 2d + s >= 0
  function automatic logic axis_ok(logic signed [DW-1:0] d, logic [SW-1:0] s);
    logic signed [CW-1:0] d2;
    logic signed [CW-1:0] s2;
    logic signed [CW-1:0] t;
    d2 = {d[DW-1], d, 1'b0};
    s2 = {2'b00, s};
    t  = d2 + s2;
    return (d2 <= s2) && !t[CW-1];
  endfunction

  assign in_stall = hold || (fr_valid && q_full);
  assign accept   = in_valid && !in_stall;
  assign q_push   = fr_valid && !q_full;

  assign ov_x         = axis_ok(fr_dx, fr_sx);
  assign ov_y         = axis_ok(fr_dy, fr_sy);
  assign q_idx        = fr_idx;
  assign q_flags.ov   = ov_x && ov_y;
  assign q_flags.dead = fr_dead;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (accept) begin
      fr_valid <= 1'b1;
    end else if (q_push) begin
      fr_valid <= 1'b0;
    end
    if (accept) begin
      fr_idx  <= {left_id, right_id};
      fr_dead <= left_dead || right_dead;
      fr_dx   <= DW'(left_x) - DW'(right_x);
      fr_dy   <= DW'(left_y) - DW'(right_y);
      fr_sx   <= SW'(left_w) + SW'(right_w);
      fr_sy   <= SW'(left_h) + SW'(right_h);
    end
  end

endmodule

// ----- src/apct_queue.sv -----
// Small register FIFO between the front and back ends.
// No dependencies.
module apct_queue #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entry [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/apct_back.sv -----
// Back end: read-modify-write of the pair overlap table, event decode and
// output register. Clears the table after reset. Uses apct_pkg, apct_ram.
module apct_back #(
  parameter int ID_BITS = apct_pkg::ID_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  output logic                  clearing,
  input  logic                  q_valid,
  input  logic [2*ID_BITS-1:0]  q_idx,
  input  apct_pkg::pair_flags_t q_flags,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            contact_event,
  output logic                  boxes_overlap
);

  localparam int IDX_W = 2 * ID_BITS;
  localparam int DEPTH = 1 << IDX_W;

  logic [IDX_W-1:0]      clr_cnt;
  logic                  b1_valid;
  logic [IDX_W-1:0]      b1_idx;
  apct_pkg::pair_flags_t b1_flags;
  logic                  b1_fwd;
  logic                  b1_fwd_val;
  logic                  b1_done;
  logic                  issue;
  logic                  prev;
  logic                  rdata;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic                  wr_val;
  logic [1:0]            ev_next;

  assign b1_done = b1_valid && (!out_valid || !out_stall);
  assign issue   = q_valid && !clearing && (!b1_valid || b1_done);
  assign q_pop   = issue;

  assign wr_en  = clearing || b1_done;
  assign wr_idx = clearing ? clr_cnt : b1_idx;
  assign wr_val = clearing ? 1'b0 : b1_flags.ov;

  // Write issued alongside this item's read is not seen by the RAM read
  assign prev = b1_fwd ? b1_fwd_val : rdata;

  always_comb begin
    priority if (b1_flags.ov && prev) begin
      ev_next = b1_flags.dead ? apct_pkg::EV_END : apct_pkg::EV_STAY;
    end else if (b1_flags.ov) begin
      ev_next = b1_flags.dead ? apct_pkg::EV_NONE : apct_pkg::EV_BEGIN;
    end else if (prev) begin
      ev_next = apct_pkg::EV_END;
    end else begin
      ev_next = apct_pkg::EV_NONE;
    end
  end

  apct_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx),
    .wdata(wr_val),
    .re   (issue),
    .raddr(q_idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      b1_valid  <= 1'b0;
      b1_fwd    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == IDX_W'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (issue) begin
        b1_valid <= 1'b1;
        b1_fwd   <= b1_done && (b1_idx == q_idx);
      end else if (b1_done) begin
        b1_valid <= 1'b0;
      end
      if (b1_done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (issue) begin
      b1_idx     <= q_idx;
      b1_flags   <= q_flags;
      b1_fwd_val <= b1_flags.ov;
    end
    if (b1_done) begin
      contact_event <= ev_next;
      boxes_overlap <= b1_flags.ov;
    end
  end

endmodule

// ----- src/aabb_pair_contact_tracker.sv -----
// Top level of the AABB pair contact tracker: front end, queue, back end.
// Depends on apct_pkg, apct_front, apct_queue, apct_back, apct_ram.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | left/right id, x, y, w, h, dead
//   out     | out_valid / out_stall| contact_event, boxes_overlap
//
// Sustains one transfer per cycle when out_stall is low and no sweep runs;
// the table read-modify-write forwards the previous write, so repeated
// pairs run back to back. An input item passes through the front-end
// registers, the queue and the back-end stage before out_valid rises.
// After reset the table's 2^(2*ID_BITS) entries (4096 at the default) are
// swept clear, with in_stall held high throughout.
// Output stalls back up through the queue into in_stall.
module aabb_pair_contact_tracker #(
  parameter int ID_BITS = apct_pkg::ID_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ID_BITS-1:0]                left_id,
  input  logic [ID_BITS-1:0]                right_id,
  input  logic signed [apct_pkg::POS_W-1:0] left_x,
  input  logic signed [apct_pkg::POS_W-1:0] left_y,
  input  logic signed [apct_pkg::POS_W-1:0] right_x,
  input  logic signed [apct_pkg::POS_W-1:0] right_y,
  input  logic [apct_pkg::SIZE_W-1:0]       left_w,
  input  logic [apct_pkg::SIZE_W-1:0]       left_h,
  input  logic [apct_pkg::SIZE_W-1:0]       right_w,
  input  logic [apct_pkg::SIZE_W-1:0]       right_h,
  input  logic                              left_dead,
  input  logic                              right_dead,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        contact_event,
  output logic                              boxes_overlap
);

  localparam int IDX_W = 2 * ID_BITS;
  localparam int QW    = IDX_W + apct_pkg::FLAGS_W;

  logic                  clearing;
  logic                  q_push;
  logic [IDX_W-1:0]      f_idx;
  apct_pkg::pair_flags_t f_flags;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;
  logic [QW-1:0]         q_head;
  logic [IDX_W-1:0]      b_idx;
  apct_pkg::pair_flags_t b_flags;

  assign b_idx   = q_head[QW-1 -: IDX_W];
  assign b_flags = apct_pkg::pair_flags_t'(q_head[apct_pkg::FLAGS_W-1:0]);

  apct_front #(
    .ID_BITS(ID_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .left_id   (left_id),
    .right_id  (right_id),
    .left_x    (left_x),
    .left_y    (left_y),
    .right_x   (right_x),
    .right_y   (right_y),
    .left_w    (left_w),
    .left_h    (left_h),
    .right_w   (right_w),
    .right_h   (right_h),
    .left_dead (left_dead),
    .right_dead(right_dead),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_idx     (f_idx),
    .q_flags   (f_flags)
  );

  apct_queue #(
    .WIDTH(QW),
    .DEPTH(apct_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data({f_idx, f_flags}),
    .pop      (q_pop),
    .pop_data (q_head),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  apct_back #(
    .ID_BITS(ID_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .q_valid      (q_not_empty),
    .q_idx        (b_idx),
    .q_flags      (b_flags),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .contact_event(contact_event),
    .boxes_overlap(boxes_overlap)
  );

endmodule

// ----- src/apct_checker.sv -----
// Port-level checker for the AABB pair contact tracker, bound to the top.
// Depends on apct_pkg and aabb_pair_contact_tracker_macros.svh.
`include "aabb_pair_contact_tracker_macros.svh"

module apct_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] contact_event,
  input logic       boxes_overlap
);

  logic [3:0] in_flight;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (in_xfer && !out_xfer) begin
      in_flight <= in_flight + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      in_flight <= in_flight - 1'b1;
    end
  end

  // No result without an item behind it
  `APCT_ASSERT_NOW(a_no_invented, out_valid, in_flight != 4'd0)

  // Begin and stay only come with overlap
  `APCT_ASSERT_NOW(a_begin_stay_ov,
    out_valid && (contact_event == apct_pkg::EV_BEGIN ||
                  contact_event == apct_pkg::EV_STAY),
    boxes_overlap)

  // Without overlap only none or end
  `APCT_ASSERT_NOW(a_sep_event, out_valid && !boxes_overlap,
    contact_event == apct_pkg::EV_NONE || contact_event == apct_pkg::EV_END)

  // Table sweep holds the input off right after reset
  `APCT_ASSERT_NOW(a_clear_stall, $fell(rst), in_stall)

  // Stalled result holds
  `APCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(contact_event) && $stable(boxes_overlap))

endmodule

bind aabb_pair_contact_tracker apct_checker u_apct_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .contact_event(contact_event),
  .boxes_overlap(boxes_overlap)
);
